// ===== sv/icmp_reply_parser_assert.svh =====
// Assertion macros shared by the ICMP reply parser RTL.
`ifndef ICMP_REPLY_PARSER_ASSERT_SVH
`define ICMP_REPLY_PARSER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ICMPRP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ICMPRP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/icmprp_pkg.sv =====
// Types and constants of the ICMP reply parser.
package icmprp_pkg;

    localparam logic [3:0] IHL_MASK        = 4'hF;
    localparam logic [7:0] TYPE_ECHO_REPLY = 8'd0;
    localparam logic [7:0] TYPE_TS_REPLY   = 8'd14;
    localparam logic [4:0] ECHO_HDR_BYTES  = 5'd12;
    localparam logic [4:0] TS_HDR_BYTES    = 5'd20;
    localparam logic [7:0] COUNT_MAX       = 8'd255;

    // Offsets from the ICMP header start
    localparam logic [7:0] OFS_TYPE  = 8'd0;
    localparam logic [7:0] OFS_ID0   = 8'd4;
    localparam logic [7:0] OFS_ID1   = 8'd5;
    localparam logic [7:0] OFS_SEQ0  = 8'd6;
    localparam logic [7:0] OFS_SEQ1  = 8'd7;
    localparam logic [7:0] OFS_ORIG  = 8'd8;
    localparam logic [7:0] OFS_RECV  = 8'd12;
    localparam logic [7:0] OFS_XMIT  = 8'd16;
    localparam logic [7:0] OFS_END   = 8'd20;

    localparam logic REG_REPLY_MODE  = 1'b0;
    localparam logic REG_EXPECTED_ID = 1'b1;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 240;

    typedef enum logic [1:0] {
        ST_ACCEPTED   = 2'd0,
        ST_WRONG_TYPE = 2'd1,
        ST_TOO_SHORT  = 2'd2,
        ST_ID_MISMATCH = 2'd3
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [15:0]        sequence_res;
        logic [31:0]        originate_time;
        logic [31:0]        receive_time;
        logic [31:0]        transmit_time;
        logic [26:0]        finish_time;
        logic signed [31:0] round_trip;
        logic signed [31:0] down_delay;
        logic signed [31:0] up_delay;
    } t_result;

endpackage

// ===== sv/icmp_reply_parser.sv =====
// ICMP reply parser top level: input register, config registers, result register.
// Usage:
//   Slave stream: one datagram byte per beat. tdata[7:0] is the byte, tdata[34:8]
//   the current millisecond-of-day; tlast marks the final byte of the datagram.
//   Master stream: one result beat per datagram, issued for the tlast byte.
//   Config channel: index 0 writes reply_mode (bit 0), index 1 writes the expected
//   identifier (bits 15:0, first wire byte high). Always ready; write while idle.
// Timing:
//   Every byte passes an input register, then capture logic; the result of a
//   tlast byte lands in the output register, which drives the master stream.
//   Throughput is one byte per cycle; only the output register's occupancy can
//   hold a tlast byte in the input register.
// Reset (synchronous, active low) empties both registers, clears the capture
//   state and sets timestamp mode with identifier zero.
// Stall: while the receiver holds tready low, non-last bytes keep flowing; a
//   second tlast byte waits in the input register and s_axis_tready drops.
module icmp_reply_parser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // [7:0] data_byte, [34:8] now_ms, rest zero
    input  logic [icmprp_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // [1:0] status, [17:2] sequence_res, [49:18] originate_time,
    // [81:50] receive_time, [113:82] transmit_time, [140:114] finish_time,
    // [172:141] round_trip, [204:173] down_delay, [236:205] up_delay, rest zero
    output logic [icmprp_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [15:0]                       i_cfg_data
);
    import icmprp_pkg::*;

    logic        r_reply_mode;
    logic [15:0] r_expected_id;

    logic        r_s1_valid;
    logic [7:0]  r_s1_byte;
    logic        r_s1_last;
    logic [26:0] r_s1_now;

    logic        r_out_valid;
    t_result     r_out;

    t_result     core_result;
    logic        out_free;
    logic        s1_go;
    logic        s_accept;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign s1_go           = r_s1_valid && (!r_s1_last || out_free);
    assign o_s_axis_tready = !r_s1_valid || s1_go;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reply_mode  <= 1'b1;
            r_expected_id <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_REPLY_MODE:  r_reply_mode  <= i_cfg_data[0];
                REG_EXPECTED_ID: r_expected_id <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_byte <= i_s_axis_tdata[7:0];
            r_s1_now  <= i_s_axis_tdata[34:8];
            r_s1_last <= i_s_axis_tlast;
        end
    end

    icmprp_core u_core (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_beat_valid          (s1_go),
        .i_data_byte           (r_s1_byte),
        .i_last                (r_s1_last),
        .i_now_ms              (r_s1_now),
        .i_reply_mode          (r_reply_mode),
        .i_expected_identifier (r_expected_id),
        .o_result              (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_out <= core_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out.up_delay, r_out.down_delay, r_out.round_trip,
                              r_out.finish_time, r_out.transmit_time, r_out.receive_time,
                              r_out.originate_time, r_out.sequence_res, r_out.status};

`include "icmp_reply_parser_assert.svh"

    `ICMPRP_ASSERT_IMP(a_stall_only_on_last, r_s1_valid && !s1_go, r_s1_last && r_out_valid && !i_m_axis_tready, "input stage stalled without a blocked result")
    `ICMPRP_ASSERT_IMP(a_reject_zero_fields, r_out_valid && r_out.status != ST_ACCEPTED, r_out.sequence_res == 16'd0 && r_out.originate_time == 32'd0 && r_out.finish_time == 27'd0 && r_out.round_trip == 32'sd0, "rejected result carries nonzero fields")
    `ICMPRP_ASSERT_NXT(a_echo_no_stamps, s1_go && r_s1_last && !r_reply_mode, r_out.receive_time == 32'd0 && r_out.transmit_time == 32'd0 && r_out.down_delay == 32'sd0 && r_out.up_delay == 32'sd0, "echo result carries timestamp fields")

endmodule

// ===== sv/icmprp_core.sv =====
// Per-datagram capture state and result computation of the ICMP reply parser.
module icmprp_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_beat_valid,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last,
    input  logic [26:0]          i_now_ms,
    input  logic                 i_reply_mode,
    input  logic [15:0]          i_expected_identifier,
    output icmprp_pkg::t_result  o_result
);
    import icmprp_pkg::*;

    logic [7:0]  r_byte_count, n_byte_count;
    logic [5:0]  r_ip_header_bytes, n_ip_header_bytes;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_ident, n_ident;
    logic [15:0] r_seq, n_seq;
    logic [31:0] r_orig, n_orig;
    logic [31:0] r_recv, n_recv;
    logic [31:0] r_xmit, n_xmit;

    logic [5:0]  hl;
    logic [7:0]  rel;
    logic        in_win;
    logic [8:0]  need_end;
    logic        too_short;
    t_status     status;
    logic [31:0] now32;

    always_comb begin
        hl = (r_byte_count == 8'd0) ? {i_data_byte[3:0] & IHL_MASK, 2'b00} : r_ip_header_bytes;
        rel = r_byte_count - {2'b00, hl};
        in_win = (r_byte_count >= {2'b00, hl}) && (rel < OFS_END);

        n_ip_header_bytes = hl;
        n_byte_count = (r_byte_count == COUNT_MAX) ? r_byte_count : r_byte_count + 8'd1;
        n_type  = r_type;
        n_ident = r_ident;
        n_seq   = r_seq;
        n_orig  = r_orig;
        n_recv  = r_recv;
        n_xmit  = r_xmit;
        if (in_win) begin
            priority if (rel == OFS_TYPE) begin
                n_type = i_data_byte;
            end else if (rel == OFS_ID0 || rel == OFS_ID1) begin
                n_ident = {r_ident[7:0], i_data_byte};
            end else if (rel == OFS_SEQ0 || rel == OFS_SEQ1) begin
                n_seq = {r_seq[7:0], i_data_byte};
            end else if (rel >= OFS_ORIG && rel < OFS_RECV) begin
                n_orig = {r_orig[23:0], i_data_byte};
            end else if (rel >= OFS_RECV && rel < OFS_XMIT) begin
                n_recv = {r_recv[23:0], i_data_byte};
            end else if (rel >= OFS_XMIT) begin
                n_xmit = {r_xmit[23:0], i_data_byte};
            end else begin
                n_type = r_type;
            end
        end

        // Checks see the state including the current (last) byte
        need_end  = {3'b000, hl} + {4'b0000, (i_reply_mode ? TS_HDR_BYTES : ECHO_HDR_BYTES)};
        too_short = need_end > {1'b0, n_byte_count};
        if (n_type != (i_reply_mode ? TYPE_TS_REPLY : TYPE_ECHO_REPLY)) begin
            status = ST_WRONG_TYPE;
        end else if (too_short) begin
            status = ST_TOO_SHORT;
        end else if (n_ident != i_expected_identifier) begin
            status = ST_ID_MISMATCH;
        end else begin
            status = ST_ACCEPTED;
        end

        now32 = {5'b00000, i_now_ms};
        o_result = '0;
        o_result.status = status;
        if (status == ST_ACCEPTED) begin
            o_result.sequence_res   = n_seq;
            o_result.originate_time = n_orig;
            o_result.finish_time    = i_now_ms;
            o_result.round_trip     = now32 - n_orig;
            if (i_reply_mode) begin
                o_result.receive_time  = n_recv;
                o_result.transmit_time = n_xmit;
                o_result.down_delay    = now32 - n_xmit;
                o_result.up_delay      = n_recv - n_orig;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_beat_valid && i_last)) begin
            r_byte_count      <= '0;
            r_ip_header_bytes <= '0;
            r_type            <= '0;
            r_ident           <= '0;
            r_seq             <= '0;
            r_orig            <= '0;
            r_recv            <= '0;
            r_xmit            <= '0;
        end else if (i_beat_valid) begin
            r_byte_count      <= n_byte_count;
            r_ip_header_bytes <= n_ip_header_bytes;
            r_type            <= n_type;
            r_ident           <= n_ident;
            r_seq             <= n_seq;
            r_orig            <= n_orig;
            r_recv            <= n_recv;
            r_xmit            <= n_xmit;
        end
    end

endmodule

// ===== dv/tb_icmp_reply_parser.sv =====
// Testbench for the ICMP reply parser: directed and random datagrams checked by a scoreboard.
module tb_icmp_reply_parser;
    timeunit 1ns;
    timeprecision 1ps;
    import icmprp_pkg::*;

    localparam int BYTE_TARGET = 1650;
    localparam int STUCK_LIMIT = 1000;

    typedef struct packed {
        t_status            status;
        logic [15:0]        seq;
        logic [31:0]        orig;
        logic [31:0]        recv;
        logic [31:0]        xmit;
        logic [26:0]        finish;
        logic signed [31:0] rtt;
        logic signed [31:0] down;
        logic signed [31:0] up;
    } t_reply;

    class reply_scoreboard;
        bit          ts_mode = 1'b1;
        logic [15:0] want_id = '0;
        logic [7:0]  count = '0;
        logic [5:0]  hdr_len = '0;
        logic [7:0]  type_byte = '0;
        logic [15:0] ident = '0;
        logic [15:0] seq = '0;
        logic [31:0] orig = '0;
        logic [31:0] recv = '0;
        logic [31:0] xmit = '0;
        t_reply      replies_due[$];
        int          errors = 0;
        int          results = 0;
        int          status_hits[4] = '{0, 0, 0, 0};

        function void write_reg(logic idx, logic [15:0] val);
            if (idx == REG_REPLY_MODE)
                ts_mode = val[0];
            else
                want_id = val;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        // Accepted input beat: capture by offset from the ICMP header, predict on the last byte.
        function void note_byte(logic [7:0] b, logic fin, logic [26:0] now);
            logic [7:0] rel;
            logic [7:0] need;
            t_reply     r;
            if (count == 0)
                hdr_len = {b[3:0], 2'b00};
            rel = count - {2'b00, hdr_len};
            if (count >= {2'b00, hdr_len} && rel < OFS_END) begin
                if (rel == OFS_TYPE)
                    type_byte = b;
                else if (rel == OFS_ID0 || rel == OFS_ID1)
                    ident = {ident[7:0], b};
                else if (rel == OFS_SEQ0 || rel == OFS_SEQ1)
                    seq = {seq[7:0], b};
                else if (rel >= OFS_ORIG && rel < OFS_RECV)
                    orig = {orig[23:0], b};
                else if (rel >= OFS_RECV && rel < OFS_XMIT)
                    recv = {recv[23:0], b};
                else if (rel >= OFS_XMIT)
                    xmit = {xmit[23:0], b};
            end
            if (count != COUNT_MAX)
                count++;
            if (!fin)
                return;

            r = '0;
            if (ts_mode) begin
                r.status = (type_byte == TYPE_TS_REPLY) ? ST_ACCEPTED : ST_WRONG_TYPE;
                need = 8'(TS_HDR_BYTES);
            end else begin
                r.status = (type_byte == TYPE_ECHO_REPLY) ? ST_ACCEPTED : ST_WRONG_TYPE;
                need = 8'(ECHO_HDR_BYTES);
            end
            if (r.status == ST_ACCEPTED && 9'(hdr_len) + 9'(need) > 9'(count))
                r.status = ST_TOO_SHORT;
            if (r.status == ST_ACCEPTED && ident != want_id)
                r.status = ST_ID_MISMATCH;
            if (r.status == ST_ACCEPTED) begin
                r.seq    = seq;
                r.orig   = orig;
                r.finish = now;
                r.rtt    = {5'd0, now} - orig;
                if (ts_mode) begin
                    r.recv = recv;
                    r.xmit = xmit;
                    r.down = {5'd0, now} - xmit;
                    r.up   = recv - orig;
                end
            end
            replies_due.push_back(r);

            count = '0;
            hdr_len = '0;
            type_byte = '0;
            ident = '0;
            seq = '0;
            orig = '0;
            recv = '0;
            xmit = '0;
        endfunction

        function void field_check(string name, logic [31:0] e, logic [31:0] g);
            if (e !== g) begin
                errors++;
                if (errors <= 10)
                    $display("result %0d: %s expected %h, got %h", results, name, e, g);
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] d);
            t_reply want;
            results++;
            if (replies_due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result %0d arrived with no datagram outstanding", results);
                return;
            end
            want = replies_due.pop_front();
            status_hits[int'(want.status)]++;
            field_check("status", want.status, d[1:0]);
            field_check("sequence", want.seq, d[17:2]);
            field_check("originate", want.orig, d[49:18]);
            field_check("receive", want.recv, d[81:50]);
            field_check("transmit", want.xmit, d[113:82]);
            field_check("finish", want.finish, d[140:114]);
            field_check("round trip", want.rtt, d[172:141]);
            field_check("down delay", want.down, d[204:173]);
            field_check("up delay", want.up, d[236:205]);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_index = REG_REPLY_MODE;
    logic [15:0]           cfg_data = '0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_cfg_ready;

    reply_scoreboard sb = new;
    logic [7:0]      frame_q[$];
    bit              cur_ts = 1'b1;
    logic [15:0]     cur_id = '0;
    bit              calm = 1'b0;
    int              bytes_sent = 0;
    int              frames_sent = 0;
    int              settings = 1;
    int              stuck = 0;

    icmp_reply_parser dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        m_tready <= calm || ($urandom_range(99) >= 30);
    end

    // Results are checked before the same edge's input beat is noted.
    always @(posedge clk) begin
        if (rst_n) begin
            if (o_m_axis_tvalid && m_tready)
                sb.check_result(o_m_axis_tdata);
            if (s_tvalid && o_s_axis_tready)
                sb.note_byte(s_tdata[7:0], s_tlast, s_tdata[34:8]);
            if (cfg_valid && o_cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if ((o_m_axis_tvalid && m_tready) || (s_tvalid && o_s_axis_tready)
                    || (cfg_valid && o_cfg_ready))
                stuck = 0;
            else
                stuck++;
            if (stuck >= STUCK_LIMIT) begin
                $display("no beat moved for %0d cycles", STUCK_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_beat(logic [7:0] b, logic fin);
        logic [26:0] now;
        now = ($urandom_range(7) == 0) ? 27'h7FF_FFFF : 27'($urandom_range(86399999));
        if (!calm) begin
            while ($urandom_range(99) < 30) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, now, b};
        s_tlast  <= fin;
        do @(posedge clk); while (!o_s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_q[i])
            send_beat(frame_q[i], i == frame_q.size() - 1);
        frames_sent++;
    endtask

    // Random bytes, then the IHL nibble, ICMP type and identifier where the frame reaches.
    task automatic make_frame(int ihl, logic [7:0] typ, logic [15:0] id, int body);
        int ofs;
        ofs = ihl * 4;
        frame_q.delete();
        repeat (ofs + body)
            frame_q.push_back(8'($urandom));
        frame_q[0][3:0] = 4'(ihl);
        if (ofs < frame_q.size())
            frame_q[ofs] = typ;
        if (ofs + 5 < frame_q.size()) begin
            frame_q[ofs + 4] = id[15:8];
            frame_q[ofs + 5] = id[7:0];
        end
    endtask

    task automatic put_be(int ofs, logic [31:0] v);
        for (int k = 0; k < 4; k++)
            if (ofs + k < frame_q.size())
                frame_q[ofs + k] = v[31 - 8 * k -: 8];
    endtask

    // Drop tvalid and wait for the clock first so the last beat of the frame is already noted.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic program_regs(bit ts, logic [15:0] id);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= REG_REPLY_MODE;
        cfg_data  <= {15'd0, ts};
        do @(posedge clk); while (!o_cfg_ready);
        cfg_index <= REG_EXPECTED_ID;
        cfg_data  <= id;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        cur_ts = ts;
        cur_id = id;
        settings++;
    endtask

    task automatic random_frame();
        int          pick;
        int          ihl;
        int          need;
        int          body;
        logic [7:0]  typ;
        logic [15:0] id;
        pick = $urandom_range(99);
        need = cur_ts ? 20 : 12;
        ihl  = ($urandom_range(9) < 6) ? 5 : $urandom_range(15);
        typ  = cur_ts ? TYPE_TS_REPLY : TYPE_ECHO_REPLY;
        id   = cur_id;
        body = need + $urandom_range(8);
        if (pick >= 70 && pick < 76) begin
            id = 16'($urandom);
        end else if (pick >= 76 && pick < 80) begin
            if ($urandom_range(1) == 1)
                typ = cur_ts ? TYPE_ECHO_REPLY : TYPE_TS_REPLY;
            else
                typ = 8'($urandom);
        end else if (pick >= 80 && pick < 90) begin
            body = $urandom_range(need - 1);
        end else if (pick >= 90 && pick < 93) begin
            body = $urandom_range(290, 250);
        end else if (pick >= 93) begin
            typ  = 8'($urandom);
            id   = 16'($urandom);
            body = $urandom_range(40, 1);
        end
        if (ihl * 4 + body == 0)
            body = 1;
        make_frame(ihl, typ, id, body);
        send_frame();
    endtask

    initial begin
        int first_bytes;
        int quota;
        int n;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset setting: timestamp mode, identifier zero.
        make_frame(5, TYPE_TS_REPLY, 16'h0000, 20);
        put_be(28, 32'hFFFF_FFFF);
        put_be(32, 32'h0000_0000);
        put_be(36, 32'h8000_0000);
        send_frame();
        frame_q = '{8'h45};              // type byte never arrives
        send_frame();
        make_frame(1, TYPE_TS_REPLY, 16'h0000, 20);
        frame_q[10] = 8'hFF;
        frame_q[11] = 8'hFF;
        send_frame();
        make_frame(5, TYPE_TS_REPLY, 16'h0000, 19);
        send_frame();

        program_regs(1'b0, 16'hFFFF);
        make_frame(0, TYPE_ECHO_REPLY, 16'hFFFF, 12);   // header at the first byte
        send_frame();
        frame_q = '{8'h45};
        send_frame();
        make_frame(5, 8'd8, 16'hFFFF, 12);
        send_frame();
        make_frame(5, TYPE_ECHO_REPLY, 16'h0000, 12);
        send_frame();
        make_frame(15, TYPE_ECHO_REPLY, 16'hFFFF, 12);
        send_frame();
        make_frame(5, TYPE_ECHO_REPLY, 16'hFFFF, 280);   // byte count saturates
        send_frame();
        first_bytes = bytes_sent;

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: program_regs(1'b0, 16'h0000);
                1: program_regs(1'b1, 16'hFFFF);
                default: program_regs(1'($urandom_range(1)), 16'($urandom));
            endcase
            calm = (p == 2);
            quota = first_bytes + (BYTE_TARGET - first_bytes) * (p + 1) / 6;
            n = 0;
            while (bytes_sent < quota) begin
                random_frame();
                n++;
                if (p == 1 && n == 6)
                    settle();
            end
        end
        calm = 1'b0;

        settle();
        repeat (10) @(posedge clk);
        $display("%0d datagrams (%0d bytes) over %0d register settings, %0d results checked",
                 frames_sent, bytes_sent, settings, sb.results);
        $display("status mix accepted/wrong type/too short/id mismatch: %0d/%0d/%0d/%0d",
                 sb.status_hits[0], sb.status_hits[1], sb.status_hits[2], sb.status_hits[3]);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
